FILE: rtl/emg_segment_feature_extractor_core_assert.svh
// assertion macros shared by the segment feature extractor rtl
`ifndef EMG_SEGMENT_FEATURE_EXTRACTOR_CORE_ASSERT_SVH
`define EMG_SEGMENT_FEATURE_EXTRACTOR_CORE_ASSERT_SVH

// condition must never hold outside reset
`define EMGSF_ASSERT_NEVER(name, clk, rst, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// antecedent implies consequent in the same cycle
`define EMGSF_ASSERT_IMPLIES(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/emgsf_pkg.sv
// shared types and constants for the segment feature extractor
package emgsf_pkg;

  localparam int SAMPLE_BITS_DEF = 12;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 32;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_LEVEL_THRESHOLD = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_LENGTH      = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LENGTH      = 2'd2;

  localparam int LEVEL_THRESHOLD_RESET = 400;
  localparam int MIN_LENGTH_RESET      = 700;
  localparam int MAX_LENGTH_RESET      = 15000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_ROOT_WAIT,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DIV,
    PH_ROOT
  } phase_t;

  typedef struct packed {
    logic start;
  } root_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } root_status_t;

endpackage

FILE: rtl/emgsf_root_div.sv
// serial mean-and-root unit: restoring divide then digit-by-digit square root
module emgsf_root_div import emgsf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  root_ctrl_t                           ctrl,
  input  logic [2*SAMPLE_BITS+LENGTH_BITS-1:0] dividend,
  input  logic [LENGTH_BITS:0]                 divisor,
  output root_status_t                         status,
  output logic [SAMPLE_BITS-1:0]               root
);

  localparam int SQ_BITS   = 2 * SAMPLE_BITS + LENGTH_BITS;
  localparam int RAD_BITS  = 2 * SAMPLE_BITS;
  localparam int ALU_BITS  = SAMPLE_BITS + LENGTH_BITS + 2;
  localparam int STEP_BITS = $clog2(SQ_BITS);

  phase_t                   phase;
  logic [STEP_BITS-1:0]     step;
  logic [SQ_BITS-1:0]       work;
  logic [ALU_BITS-1:0]      rem;
  logic [LENGTH_BITS:0]     divisor_reg;
  logic [SAMPLE_BITS-1:0]   root_reg;

  logic [ALU_BITS-1:0]      op_a;
  logic [ALU_BITS-1:0]      op_b;
  logic [ALU_BITS:0]        diff;
  logic                     fits;

  // one shared subtractor serves both the divide and the root steps
  always_comb begin
    case (phase)
      PH_DIV: begin
        op_a = {rem[ALU_BITS-2:0], work[SQ_BITS-1]};
        op_b = ALU_BITS'(divisor_reg);
      end
      PH_ROOT: begin
        op_a = {rem[ALU_BITS-3:0], work[RAD_BITS-1:RAD_BITS-2]};
        op_b = ALU_BITS'({root_reg, 2'b01});
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    diff = {1'b0, op_a} - {1'b0, op_b};
    fits = !diff[ALU_BITS];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      step  <= '0;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (ctrl.start) begin
            phase <= PH_DIV;
            step  <= STEP_BITS'(SQ_BITS - 1);
          end
        end
        PH_DIV: begin
          if (step == '0) begin
            phase <= PH_ROOT;
            step  <= STEP_BITS'(SAMPLE_BITS - 1);
          end else begin
            step <= step - 1'b1;
          end
        end
        PH_ROOT: begin
          if (step == '0) begin
            phase <= PH_IDLE;
          end else begin
            step <= step - 1'b1;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (phase)
      PH_IDLE: begin
        if (ctrl.start) begin
          work        <= dividend;
          divisor_reg <= divisor;
          rem         <= '0;
        end
      end
      PH_DIV: begin
        work <= {work[SQ_BITS-2:0], fits};
        // quotient is complete after the last step, start the root afresh
        if (step == '0) begin
          rem      <= '0;
          root_reg <= '0;
        end else begin
          rem <= fits ? diff[ALU_BITS-1:0] : op_a;
        end
      end
      PH_ROOT: begin
        rem      <= fits ? diff[ALU_BITS-1:0] : op_a;
        root_reg <= {root_reg[SAMPLE_BITS-2:0], fits};
        work     <= {work[SQ_BITS-3:0], 2'b00};
      end
      default: begin
      end
    endcase
  end

  assign status.busy = (phase != PH_IDLE);
  assign status.done = (phase == PH_ROOT) && (step == '0);
  assign root        = root_reg;

endmodule

FILE: rtl/emg_segment_feature_extractor_core.sv
// top level of the emg segment feature extractor
// usage:
// - input channel: sample with in_valid / in_stall; a request is taken when
//   in_valid is high and in_stall low. in_stall is high while a sample is
//   being worked on.
// - output channel: rms_level, waveform_length, segment_samples with
//   out_valid / out_stall; a result is held in an output register until taken.
// - config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   index 0 level threshold, 1 minimum length, 2 maximum length. cfg_ready
//   is always high; write only while no sample is in flight.
// - timing: a sample that reports no segment goes through square, update and
//   back to idle. a sample that closes an accepted segment runs the serial
//   mean-and-root unit: one bit of quotient per cycle, then one root bit per
//   cycle; both steps share one subtractor in the unit.
// - reset: segment state and cooldown clear, registers take their defaults,
//   no result is pending.
// - output stall: the result stays in the output register; a new sample is
//   still taken, and only a second result waits for the register to free.
module emg_segment_feature_extractor_core import emgsf_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_BITS-1:0]          sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [SAMPLE_BITS-1:0]          rms_level,
  output logic [SAMPLE_BITS+LENGTH_BITS-1:0] waveform_length,
  output logic [LENGTH_BITS:0]            segment_samples,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0]       cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

  localparam int SQ_BITS  = 2 * SAMPLE_BITS + LENGTH_BITS;
  localparam int WL_BITS  = SAMPLE_BITS + LENGTH_BITS;
  localparam int CNT_BITS = LENGTH_BITS + 1;

  // configuration
  logic [SAMPLE_BITS-1:0]   level_threshold;
  logic [LENGTH_BITS-1:0]   min_length;
  logic [LENGTH_BITS-1:0]   max_length;

  // sequencer
  state_t state;
  state_t state_next;

  // segment state
  logic                     segment_active;
  logic                     cooldown;
  logic [CNT_BITS-1:0]      sample_count;
  logic [SQ_BITS-1:0]       square_sum;
  logic [WL_BITS-1:0]       abs_diff_sum;
  logic [SAMPLE_BITS-1:0]   previous_sample;

  logic                     segment_active_next;
  logic                     cooldown_next;
  logic [CNT_BITS-1:0]      sample_count_next;
  logic [SQ_BITS-1:0]       square_sum_next;
  logic [WL_BITS-1:0]       abs_diff_sum_next;
  logic [SAMPLE_BITS-1:0]   previous_sample_next;

  // working registers
  logic [SAMPLE_BITS-1:0]   sample_reg;
  logic [2*SAMPLE_BITS-1:0] square;
  logic [WL_BITS-1:0]       res_wl;
  logic [CNT_BITS-1:0]      res_cnt;

  // update decode
  logic                     high;
  logic                     report;
  logic [SAMPLE_BITS-1:0]   abs_diff;
  logic [WL_BITS:0]         wl_sum;
  logic [WL_BITS-1:0]       wl_acc;
  logic [CNT_BITS-1:0]      count_acc;
  logic [SQ_BITS-1:0]       sum_acc;

  // control
  logic                     in_accept;
  logic                     out_load;
  root_ctrl_t               root_ctrl;
  root_status_t             root_status;
  logic [SAMPLE_BITS-1:0]   root;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_threshold <= SAMPLE_BITS'(LEVEL_THRESHOLD_RESET);
      min_length      <= LENGTH_BITS'(MIN_LENGTH_RESET);
      max_length      <= LENGTH_BITS'(MAX_LENGTH_RESET);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEVEL_THRESHOLD: level_threshold <= cfg_data[SAMPLE_BITS-1:0];
        CFG_MIN_LENGTH:      min_length      <= cfg_data[LENGTH_BITS-1:0];
        CFG_MAX_LENGTH:      max_length      <= cfg_data[LENGTH_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // segment rules, first match wins
  always_comb begin
    high      = (sample_reg >= level_threshold);
    abs_diff  = (sample_reg >= previous_sample) ? (sample_reg - previous_sample)
                                                : (previous_sample - sample_reg);
    wl_sum    = {1'b0, abs_diff_sum} + (WL_BITS + 1)'(abs_diff);
    wl_acc    = wl_sum[WL_BITS] ? {WL_BITS{1'b1}} : wl_sum[WL_BITS-1:0];
    count_acc = sample_count + 1'b1;
    sum_acc   = square_sum + SQ_BITS'(square);

    segment_active_next  = segment_active;
    cooldown_next        = cooldown;
    sample_count_next    = sample_count;
    square_sum_next      = square_sum;
    abs_diff_sum_next    = abs_diff_sum;
    previous_sample_next = previous_sample;
    report               = 1'b0;

    if (!segment_active && high && !cooldown) begin
      segment_active_next  = 1'b1;
      sample_count_next    = CNT_BITS'(1);
      square_sum_next      = SQ_BITS'(square);
      abs_diff_sum_next    = '0;
      previous_sample_next = sample_reg;
    end else if (segment_active && !high && !cooldown &&
                 (sample_count >= CNT_BITS'(min_length))) begin
      report               = 1'b1;
      segment_active_next  = 1'b0;
      sample_count_next    = '0;
      square_sum_next      = '0;
      abs_diff_sum_next    = '0;
      previous_sample_next = '0;
    end else if (segment_active && !high && !cooldown) begin
      segment_active_next  = 1'b0;
      sample_count_next    = '0;
      square_sum_next      = '0;
      abs_diff_sum_next    = '0;
      previous_sample_next = '0;
    end else if (segment_active && (sample_count >= CNT_BITS'(max_length))) begin
      segment_active_next  = 1'b0;
      cooldown_next        = 1'b1;
      sample_count_next    = '0;
      square_sum_next      = '0;
      abs_diff_sum_next    = '0;
      previous_sample_next = '0;
    end else if (!segment_active && !high && cooldown) begin
      cooldown_next     = 1'b0;
      sample_count_next = '0;
    end else if (segment_active && high && !cooldown) begin
      sample_count_next    = count_acc;
      square_sum_next      = sum_acc;
      abs_diff_sum_next    = wl_acc;
      previous_sample_next = sample_reg;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_accept) state_next = ST_SQUARE;
      ST_SQUARE:    state_next = ST_UPDATE;
      ST_UPDATE:    state_next = report ? ST_ROOT_WAIT : ST_IDLE;
      ST_ROOT_WAIT: if (root_status.done) state_next = ST_DONE;
      ST_DONE:      if (!out_valid || !out_stall) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall        = 1'b1;
    root_ctrl.start = 1'b0;
    out_load        = 1'b0;
    case (state)
      ST_IDLE:   in_stall        = 1'b0;
      ST_UPDATE: root_ctrl.start = report;
      ST_DONE:   out_load        = !out_valid || !out_stall;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      segment_active  <= 1'b0;
      cooldown        <= 1'b0;
      sample_count    <= '0;
      square_sum      <= '0;
      abs_diff_sum    <= '0;
      previous_sample <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_UPDATE) begin
        segment_active  <= segment_active_next;
        cooldown        <= cooldown_next;
        sample_count    <= sample_count_next;
        square_sum      <= square_sum_next;
        abs_diff_sum    <= abs_diff_sum_next;
        previous_sample <= previous_sample_next;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_reg <= sample;
    end
    if (state == ST_SQUARE) begin
      square <= (2*SAMPLE_BITS)'(sample_reg) * (2*SAMPLE_BITS)'(sample_reg);
    end
    if (root_ctrl.start) begin
      res_wl  <= wl_acc;
      res_cnt <= count_acc;
    end
    if (out_load) begin
      rms_level       <= root;
      waveform_length <= res_wl;
      segment_samples <= res_cnt;
    end
  end

  emgsf_root_div #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_root_div (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (root_ctrl),
    .dividend (sum_acc),
    .divisor  (count_acc),
    .status   (root_status),
    .root     (root)
  );

`include "emg_segment_feature_extractor_core_assert.svh"

  `EMGSF_ASSERT_NEVER(a_active_cooldown, clk, rst, segment_active && cooldown, "segment open during cooldown")
  `EMGSF_ASSERT_IMPLIES(a_idle_count, clk, rst, !segment_active, sample_count == '0, "count kept outside a segment")
  `EMGSF_ASSERT_IMPLIES(a_unit_busy, clk, rst, root_status.busy, state == ST_ROOT_WAIT, "root unit busy outside wait")
  `EMGSF_ASSERT_IMPLIES(a_start_idle, clk, rst, root_ctrl.start, !root_status.busy, "root unit started while busy")

endmodule
